### sv/gbft_pkg.sv
// Shared constants, codes and word types of the breadth-first graph traversal core.
`default_nettype none

package gbft_pkg;

  // Graph and result limits
  localparam int MAX_VERTICES = 16;
  localparam int MAX_DEGREE   = 16;
  localparam int RESULT_CAP   = 16;

  // Derived widths
  localparam int NAME_W = 8;
  localparam int VTX_W  = $clog2(MAX_VERTICES);
  localparam int VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int DEG_W  = $clog2(MAX_DEGREE + 1);
  localparam int ADDR_W = $clog2(MAX_VERTICES * MAX_DEGREE);
  localparam int RES_W  = $clog2(RESULT_CAP + 1);

  typedef enum logic [1:0] {
    FN_CLEAR      = 2'd0,
    FN_ADD_VERTEX = 2'd1,
    FN_ADD_EDGE   = 2'd2,
    FN_TRAVERSE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNKNOWN    = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_LIST_FULL  = 2'd3
  } status_t;

  typedef struct packed {
    func_t              func;
    logic [NAME_W-1:0]  name_a;
    logic [NAME_W-1:0]  name_b;
  } in_word_t;

  typedef struct packed {
    logic [NAME_W-1:0]  vertex_name;
    status_t            status;
    logic               last;
  } out_word_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load;
    logic    clear_graph;
    logic    add_vertex;
    logic    scan_clr;
    logic    scan_step;
    logic    append_a;
    logic    append_b;
    logic    q_init;
    logic    pop;
    logic    nbr_rd;
    logic    nbr_chk;
    logic    emit_status;
    logic    emit_final;
    status_t status;
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    func_t func;
    logic  scan_more;
    logic  found_a;
    logic  found_b;
    logic  table_full;
    logic  list_full;
    logic  q_more;
    logic  nbr_more;
  } dp_sts_t;

  // Flat neighbour store address of slot deg in the list of vertex vtx
  function automatic logic [ADDR_W-1:0] store_addr(input logic [VTX_W-1:0] vtx,
                                                   input logic [DEG_W-1:0] deg);
    store_addr = ADDR_W'(ADDR_W'(vtx) * ADDR_W'(MAX_DEGREE) + ADDR_W'(deg));
  endfunction

endpackage

`default_nettype wire

### sv/gbft_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module gbft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### sv/gbft_ctrl.sv
// Controller state machine: sequences loads, name scans, appends and the traversal.
`default_nettype none

module gbft_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire gbft_pkg::dp_sts_t sts,
  output gbft_pkg::dp_cmd_t      cmd
);

  import gbft_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_APPEND_A,
    S_APPEND_B,
    S_POP,
    S_NBR_RD,
    S_NBR_CHK
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (sts.func)
          FN_CLEAR: begin
            cmd.clear_graph = 1'b1;
            cmd.emit_status = 1'b1;
            state_nxt       = S_IDLE;
          end
          FN_ADD_VERTEX: begin
            cmd.emit_status = 1'b1;
            if (sts.table_full) begin
              cmd.status = ST_TABLE_FULL;
            end else begin
              cmd.add_vertex = 1'b1;
            end
            state_nxt = S_IDLE;
          end
          FN_ADD_EDGE, FN_TRAVERSE: begin
            cmd.scan_clr = 1'b1;
            state_nxt    = S_SCAN;
          end
        endcase
      end
      S_SCAN: begin
        if (sts.scan_more) begin
          cmd.scan_step = 1'b1;
        end else if (sts.func == FN_ADD_EDGE) begin
          if (!(sts.found_a && sts.found_b)) begin
            cmd.emit_status = 1'b1;
            cmd.status      = ST_UNKNOWN;
            state_nxt       = S_IDLE;
          end else if (sts.list_full) begin
            cmd.emit_status = 1'b1;
            cmd.status      = ST_LIST_FULL;
            state_nxt       = S_IDLE;
          end else begin
            state_nxt = S_APPEND_A;
          end
        end else begin
          if (!sts.found_a) begin
            cmd.emit_status = 1'b1;
            cmd.status      = ST_UNKNOWN;
            state_nxt       = S_IDLE;
          end else begin
            cmd.q_init = 1'b1;
            state_nxt  = S_POP;
          end
        end
      end
      S_APPEND_A: begin
        cmd.append_a = 1'b1;
        state_nxt    = S_APPEND_B;
      end
      S_APPEND_B: begin
        cmd.append_b    = 1'b1;
        cmd.emit_status = 1'b1;
        state_nxt       = S_IDLE;
      end
      S_POP: begin
        if (sts.q_more) begin
          cmd.pop   = 1'b1;
          state_nxt = S_NBR_RD;
        end else begin
          cmd.emit_final = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_NBR_RD: begin
        if (sts.nbr_more) begin
          cmd.nbr_rd = 1'b1;
          state_nxt  = S_NBR_CHK;
        end else begin
          state_nxt = S_POP;
        end
      end
      S_NBR_CHK: begin
        cmd.nbr_chk = 1'b1;
        state_nxt   = S_NBR_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

`default_nettype wire

### sv/gbft_dp.sv
// Datapath: vertex table, neighbour lists, visited marks, visit queue and result register.
`default_nettype none

module gbft_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire gbft_pkg::in_word_t  in_word,
  input  wire gbft_pkg::dp_cmd_t   cmd,
  output gbft_pkg::dp_sts_t        sts,
  output logic                     out_valid,
  output gbft_pkg::out_word_t      out_word
);

  import gbft_pkg::*;

  // Item registers
  func_t             func_r;
  logic [NAME_W-1:0] na_r;
  logic [NAME_W-1:0] nb_r;

  // Graph storage
  logic [VCNT_W-1:0]       vcnt_r;
  logic [NAME_W-1:0]       names_r [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] vis_r;
  logic [DEG_W-1:0]        cnt_r [MAX_VERTICES];

  // Name scan
  logic [VCNT_W-1:0] scan_r;
  logic              fa_r, fb_r;
  logic [VTX_W-1:0]  ia_r, ib_r;
  logic [DEG_W-1:0]  ca_r, cb_r;

  // Traversal
  logic [VTX_W-1:0]  queue_r [MAX_VERTICES];
  logic [VCNT_W-1:0] head_r, tail_r;
  logic [VTX_W-1:0]  v_r;
  logic [DEG_W-1:0]  j_r;
  logic [RES_W-1:0]  nres_r;
  logic [NAME_W-1:0] pend_r;
  logic              trav_r;

  // Result register
  logic      out_valid_r;
  out_word_t out_word_r;

  // Neighbour store
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VTX_W-1:0]  ram_wdata;
  logic [VTX_W-1:0]  w;

  logic [VTX_W-1:0]  names_idx;
  logic [VTX_W-1:0]  cnt_idx;
  logic [NAME_W-1:0] name_rd;
  logic [DEG_W-1:0]  cnt_rd;
  logic              hit_a, hit_b;
  logic [DEG_W-1:0]  cb_eff;
  logic              list_full;
  logic              w_new;
  logic              emit_w;

  // Single read port on the name and count tables
  assign names_idx = trav_r ? w : scan_r[VTX_W-1:0];
  assign cnt_idx   = trav_r ? v_r : scan_r[VTX_W-1:0];
  assign name_rd   = names_r[names_idx];
  assign cnt_rd    = cnt_r[cnt_idx];
  assign hit_a     = (name_rd == na_r);
  assign hit_b     = (name_rd == nb_r);

  // Room check; a self loop takes two slots of one list
  assign cb_eff = (ia_r == ib_r) ? DEG_W'(ca_r + DEG_W'(1)) : cb_r;
  always_comb begin
    if (ia_r == ib_r) begin
      list_full = ({1'b0, ca_r} + (DEG_W+1)'(2)) > (DEG_W+1)'(MAX_DEGREE);
    end else begin
      list_full = (ca_r >= DEG_W'(MAX_DEGREE)) || (cb_r >= DEG_W'(MAX_DEGREE));
    end
  end

  assign w_new  = !vis_r[w];
  assign emit_w = cmd.nbr_chk && w_new && (nres_r < RES_W'(RESULT_CAP));

  // Neighbour store: append writes, traversal reads
  assign ram_we    = cmd.append_a || cmd.append_b;
  assign ram_waddr = cmd.append_a ? store_addr(ia_r, ca_r) : store_addr(ib_r, cb_eff);
  assign ram_wdata = cmd.append_a ? ib_r : ia_r;

  gbft_ram #(
    .WIDTH (VTX_W),
    .DEPTH (MAX_VERTICES * MAX_DEGREE)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.nbr_rd),
    .raddr (store_addr(v_r, j_r)),
    .rdata (w)
  );

  // Status to the controller
  always_comb begin
    sts.func       = func_r;
    sts.scan_more  = (scan_r < vcnt_r);
    sts.found_a    = fa_r;
    sts.found_b    = fb_r;
    sts.table_full = (vcnt_r >= VCNT_W'(MAX_VERTICES));
    sts.list_full  = list_full;
    sts.q_more     = (head_r < tail_r);
    sts.nbr_more   = (j_r < cnt_rd);
  end

  // Control state: counts, marks, scan flags, queue pointers, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      vis_r       <= '0;
      cnt_r       <= '{default: '0};
      scan_r      <= '0;
      fa_r        <= 1'b0;
      fb_r        <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
      j_r         <= '0;
      nres_r      <= '0;
      trav_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        trav_r <= 1'b0;
      end
      if (cmd.clear_graph) begin
        vcnt_r <= '0;
        vis_r  <= '0;
        cnt_r  <= '{default: '0};
        head_r <= '0;
        tail_r <= '0;
      end
      if (cmd.add_vertex) begin
        vis_r[vcnt_r[VTX_W-1:0]] <= 1'b0;
        cnt_r[vcnt_r[VTX_W-1:0]] <= '0;
        vcnt_r                   <= VCNT_W'(vcnt_r + VCNT_W'(1));
      end
      // Scan the name table, keep the earliest match of each name
      if (cmd.scan_clr) begin
        scan_r <= '0;
        fa_r   <= 1'b0;
        fb_r   <= 1'b0;
      end
      if (cmd.scan_step) begin
        scan_r <= VCNT_W'(scan_r + VCNT_W'(1));
        if (hit_a && !fa_r) begin
          fa_r <= 1'b1;
        end
        if (hit_b && !fb_r) begin
          fb_r <= 1'b1;
        end
      end
      if (cmd.append_a) begin
        cnt_r[ia_r] <= DEG_W'(ca_r + DEG_W'(1));
      end
      if (cmd.append_b) begin
        cnt_r[ib_r] <= DEG_W'(cb_eff + DEG_W'(1));
      end
      // Seed the queue with the start vertex
      if (cmd.q_init) begin
        vis_r[ia_r] <= 1'b1;
        head_r      <= '0;
        tail_r      <= VCNT_W'(1);
        nres_r      <= RES_W'(1);
        trav_r      <= 1'b1;
      end
      if (cmd.pop) begin
        head_r <= VCNT_W'(head_r + VCNT_W'(1));
        j_r    <= '0;
      end
      if (cmd.nbr_rd) begin
        j_r <= DEG_W'(j_r + DEG_W'(1));
      end
      // Mark a newly reached vertex and enqueue it
      if (cmd.nbr_chk && w_new) begin
        vis_r[w] <= 1'b1;
        if (tail_r < VCNT_W'(MAX_VERTICES)) begin
          tail_r <= VCNT_W'(tail_r + VCNT_W'(1));
        end
        if (nres_r < RES_W'(RESULT_CAP)) begin
          nres_r <= RES_W'(nres_r + RES_W'(1));
        end
      end
      out_valid_r <= cmd.emit_status || cmd.emit_final || emit_w;
    end
  end

  // Payload: item, names, match data, queue entries, pending visit, result word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_word.func;
      na_r   <= in_word.name_a;
      nb_r   <= in_word.name_b;
    end
    if (cmd.add_vertex) begin
      names_r[vcnt_r[VTX_W-1:0]] <= na_r;
    end
    if (cmd.scan_step) begin
      if (hit_a && !fa_r) begin
        ia_r <= scan_r[VTX_W-1:0];
        ca_r <= cnt_rd;
      end
      if (hit_b && !fb_r) begin
        ib_r <= scan_r[VTX_W-1:0];
        cb_r <= cnt_rd;
      end
    end
    if (cmd.q_init) begin
      queue_r[0] <= ia_r;
      pend_r     <= na_r;
    end
    if (cmd.pop) begin
      v_r <= queue_r[head_r[VTX_W-1:0]];
    end
    if (cmd.nbr_chk && w_new && (tail_r < VCNT_W'(MAX_VERTICES))) begin
      queue_r[tail_r[VTX_W-1:0]] <= w;
    end
    if (emit_w) begin
      pend_r <= name_rd;
    end
    // Result word: status word, held visit, or closing visit
    if (cmd.emit_status) begin
      out_word_r.vertex_name <= '0;
      out_word_r.status      <= cmd.status;
      out_word_r.last        <= 1'b1;
    end else if (cmd.emit_final) begin
      out_word_r.vertex_name <= pend_r;
      out_word_r.status      <= ST_OK;
      out_word_r.last        <= 1'b1;
    end else if (emit_w) begin
      out_word_r.vertex_name <= pend_r;
      out_word_r.status      <= ST_OK;
      out_word_r.last        <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### sv/graph_breadth_first_traversal_core.sv
// Top level of the breadth-first graph traversal core: controller plus datapath.
//
// Usage: drive in_word and raise start; the word is taken at a rising edge with
// start high and busy low. func selects clear graph, add vertex, add edge or
// traverse from name_a. Results leave on out_word, each valid for exactly one
// cycle with out_valid high; the receiver cannot stall them. The final result
// of an item has last set. Non-visit results carry vertex name zero.
// Sequence per item (V = vertex count):
//   clear, add vertex: the item is decoded, then its single result is registered.
//   add edge: a sequential name scan over all V vertices, then two list appends.
//   traverse: a name scan over all V vertices, then a breadth-first walk that
//   reads the neighbours of each queued vertex one at a time through the single
//   read port of the neighbour store RAM; the last result leaves after the queue
//   runs dry.
// The next item can be accepted in the cycle the final result is shown.
// Reset (synchronous, active low) empties the graph, clears visited marks and
// returns the controller to idle; the neighbour store needs no clearing pass.
`default_nettype none

module graph_breadth_first_traversal_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire gbft_pkg::in_word_t  in_word,
  output logic                     out_valid,
  output gbft_pkg::out_word_t      out_word
);

  import gbft_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  gbft_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  gbft_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule

`default_nettype wire

### sv/gbft_checker.sv
// Port-level assertions for the traversal core and their bind to the top level.
`default_nettype none

module gbft_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire gbft_pkg::in_word_t  in_word,
  input wire logic                out_valid,
  input wire gbft_pkg::out_word_t out_word
);

  import gbft_pkg::*;

  // An accepted word keeps the core busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // busy rises only after a start request
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // More results follow a non-final one, so the core is still busy
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_word.last) |-> busy)
    else $error("non-final result while idle");

  // An error status ends the item and names no vertex
  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.status != ST_OK)) |->
      (out_word.last && (out_word.vertex_name == '0)))
    else $error("error result malformed");

  // An idle core with no word in flight shows no result
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !$past(busy) && !$past(start && !busy, 2)) |-> !out_valid)
    else $error("result while idle");

endmodule

bind graph_breadth_first_traversal_core gbft_checker u_gbft_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_word  (out_word)
);

`default_nettype wire

### tb/bfs_result_checker.sv
// Result checker for the breadth-first traversal core: predicts every result word and compares.
module bfs_result_checker
  import gbft_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  logic      busy,
  input  in_word_t  in_word,
  input  logic      out_valid,
  input  out_word_t out_word,
  output int        fail_count,
  output int        pending
);

  // Shadow copy of the graph
  logic [NAME_W-1:0] vtx_name  [MAX_VERTICES];
  int                vtx_total;
  logic              visited   [MAX_VERTICES];
  logic [VTX_W-1:0]  nbr_list  [MAX_VERTICES][MAX_DEGREE];
  int                nbr_total [MAX_VERTICES];

  out_word_t expected_words [$];
  out_word_t want;
  int        bad_words;

  initial begin
    fail_count = 0;
    pending    = 0;
    bad_words  = 0;
    vtx_total  = 0;
  end

  // Earliest vertex carrying this name, or -1
  function automatic int find_vertex(input logic [NAME_W-1:0] nm);
    for (int i = 0; i < vtx_total; i++) begin
      if (vtx_name[i] == nm) return i;
    end
    return -1;
  endfunction

  // Queue a lone result word that closes its item
  task automatic queue_single_word(input status_t st);
    expected_words.push_back('{vertex_name: '0, status: st, last: 1'b1});
  endtask

  // Apply one accepted command word to the shadow graph and queue its results
  task automatic predict_graph_word(input in_word_t iw);
    int        a, b, v, nb, head, tail, n, j;
    int        order [MAX_VERTICES];
    out_word_t visits [RESULT_CAP];
    case (iw.func)
      FN_CLEAR: begin
        vtx_total = 0;
        foreach (visited[i]) visited[i] = 1'b0;
        foreach (nbr_total[i]) nbr_total[i] = 0;
        queue_single_word(ST_OK);
      end
      FN_ADD_VERTEX: begin
        if (vtx_total >= MAX_VERTICES) begin
          queue_single_word(ST_TABLE_FULL);
        end else begin
          vtx_name[vtx_total]  = iw.name_a;
          visited[vtx_total]   = 1'b0;
          nbr_total[vtx_total] = 0;
          vtx_total++;
          queue_single_word(ST_OK);
        end
      end
      FN_ADD_EDGE: begin
        a = find_vertex(iw.name_a);
        b = find_vertex(iw.name_b);
        if (a < 0 || b < 0) begin
          queue_single_word(ST_UNKNOWN);
        end else if ((a == b && nbr_total[a] + 2 > MAX_DEGREE) ||
                     (a != b && (nbr_total[a] >= MAX_DEGREE ||
                                 nbr_total[b] >= MAX_DEGREE))) begin
          // a self loop takes two slots of the same list
          queue_single_word(ST_LIST_FULL);
        end else begin
          nbr_list[a][nbr_total[a]] = VTX_W'(b);
          nbr_total[a]++;
          nbr_list[b][nbr_total[b]] = VTX_W'(a);
          nbr_total[b]++;
          queue_single_word(ST_OK);
        end
      end
      default: begin
        a = find_vertex(iw.name_a);
        if (a < 0) begin
          queue_single_word(ST_UNKNOWN);
        end else begin
          // Start vertex goes out first even when already visited
          visited[a] = 1'b1;
          visits[0]  = '{vertex_name: vtx_name[a], status: ST_OK, last: 1'b0};
          n          = 1;
          order[0]   = a;
          head       = 0;
          tail       = 1;
          while (head < tail) begin
            v = order[head];
            head++;
            for (j = 0; j < nbr_total[v]; j++) begin
              nb = nbr_list[v][j];
              if (!visited[nb]) begin
                visited[nb] = 1'b1;
                if (n < RESULT_CAP) begin
                  visits[n] = '{vertex_name: vtx_name[nb], status: ST_OK, last: 1'b0};
                  n++;
                end
                if (tail < MAX_VERTICES) begin
                  order[tail] = nb;
                  tail++;
                end
              end
            end
          end
          visits[n-1].last = 1'b1;
          for (j = 0; j < n; j++) expected_words.push_back(visits[j]);
        end
      end
    endcase
  endtask

  // Watch both channels at each rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      vtx_total = 0;
      foreach (visited[i]) visited[i] = 1'b0;
      foreach (nbr_total[i]) nbr_total[i] = 0;
      expected_words.delete();
    end else begin
      if (start && !busy) predict_graph_word(in_word);
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          bad_words++;
          if (bad_words <= 10)
            $display("%0t bfs check: result word name %02h status %0d last %0b with none pending",
                     $time, out_word.vertex_name, out_word.status, out_word.last);
        end else begin
          want = expected_words.pop_front();
          if (out_word.vertex_name !== want.vertex_name || out_word.status !== want.status ||
              out_word.last !== want.last) begin
            bad_words++;
            if (bad_words <= 10)
              $display("%0t bfs check: expected name %02h status %0d last %0b, got %02h %0d %0b",
                       $time, want.vertex_name, want.status, want.last,
                       out_word.vertex_name, out_word.status, out_word.last);
          end
        end
      end
    end
    fail_count <= bad_words;
    pending    <= expected_words.size();
  end

endmodule

### tb/tb_top.sv
// Testbench top: drives graph command words into the traversal core and gives the verdict.
module tb_top;
  import gbft_pkg::*;

  localparam int ITEM_TARGET = 310;
  localparam int CYCLE_LIMIT = 1_000_000;

  logic      clk   = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;
  int        fail_count;
  int        pending;

  int          cycle_count = 0;
  int          words_sent  = 0;
  bit          steady      = 1'b0;
  logic [7:0]  added [$];

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  graph_breadth_first_traversal_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  bfs_result_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Drop start for a random gap: mostly none, some short, a few long
  task automatic hold_off();
    int r, gap;
    r = $urandom_range(0, 99);
    if (steady || r < 55) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offer one command word and hold it until the core takes it
  task automatic issue(input func_t f, input logic [7:0] a, input logic [7:0] b);
    in_word <= '{func: f, name_a: a, name_b: b};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    words_sent++;
    if (f == FN_CLEAR) added.delete();
    if (f == FN_ADD_VERTEX) added.push_back(a);
    hold_off();
  endtask

  // Hold the sender until every expected word has come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly a name already added, now and then any byte
  function automatic logic [7:0] pick_name();
    if (added.size() == 0 || $urandom_range(0, 9) == 0) return 8'($urandom);
    return added[$urandom_range(0, added.size() - 1)];
  endfunction

  // One graph build and walk; shape 0 fills the table, 1 fills a list,
  // 2 uses duplicate names, 3 forces a second round, 7 is noise
  task automatic play_episode(input int shape);
    int         nv, ne, nt, i;
    logic [7:0] hub, a, b;
    steady = ($urandom_range(0, 3) == 0);
    if (shape == 7) begin
      nt = $urandom_range(6, 10);
      for (i = 0; i < nt; i++)
        issue(func_t'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
    end else begin
      issue(FN_CLEAR, 8'($urandom), 8'($urandom));
      nv = (shape == 0) ? $urandom_range(16, 18) : $urandom_range(2, 9);
      for (i = 0; i < nv; i++)
        issue(FN_ADD_VERTEX, (shape == 2) ? 8'($urandom_range(0, 3)) : 8'($urandom),
              8'($urandom));
      if (shape == 1) begin
        // pile edges onto one vertex until its list overflows
        hub = added[0];
        ne  = $urandom_range(15, 19);
        for (i = 0; i < ne; i++) begin
          b = ($urandom_range(0, 5) == 0) ? hub : pick_name();
          if ($urandom_range(0, 1) == 0) issue(FN_ADD_EDGE, hub, b);
          else issue(FN_ADD_EDGE, b, hub);
        end
      end else begin
        ne = $urandom_range(0, 2 * nv);
        for (i = 0; i < ne; i++) begin
          a = pick_name();
          b = ($urandom_range(0, 11) == 0) ? a : pick_name();
          issue(FN_ADD_EDGE, a, b);
        end
      end
      nt = $urandom_range(1, 3);
      for (i = 0; i < nt; i++) issue(FN_TRAVERSE, pick_name(), 8'($urandom));
      // Grow the graph after a walk so old marks meet new vertices
      if (shape == 3 || $urandom_range(0, 1) == 0) begin
        for (i = 0; i < $urandom_range(1, 2); i++)
          issue(FN_ADD_VERTEX, 8'($urandom), 8'($urandom));
        for (i = 0; i < $urandom_range(1, 3); i++)
          issue(FN_ADD_EDGE, pick_name(), pick_name());
        for (i = 0; i < $urandom_range(1, 2); i++)
          issue(FN_TRAVERSE, pick_name(), 8'($urandom));
      end
    end
    if ($urandom_range(0, 3) == 0) drain_results();
  endtask

  // Timeout
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty graph, extreme names, duplicates, self loops, revisits
    issue(FN_TRAVERSE,   8'h00, 8'($urandom));
    issue(FN_ADD_EDGE,   8'h00, 8'hFF);
    issue(FN_ADD_VERTEX, 8'h00, 8'($urandom));
    issue(FN_ADD_VERTEX, 8'hFF, 8'($urandom));
    issue(FN_ADD_VERTEX, 8'h00, 8'($urandom));
    issue(FN_ADD_VERTEX, 8'hA5, 8'($urandom));
    issue(FN_ADD_EDGE,   8'h00, 8'hFF);
    issue(FN_ADD_EDGE,   8'hFF, 8'hFF);
    issue(FN_ADD_EDGE,   8'h00, 8'h5A);
    issue(FN_ADD_EDGE,   8'h5A, 8'h00);
    issue(FN_ADD_EDGE,   8'hA5, 8'h00);
    issue(FN_TRAVERSE,   8'hFF, 8'($urandom));
    issue(FN_TRAVERSE,   8'hFF, 8'($urandom));
    issue(FN_ADD_VERTEX, 8'h5A, 8'($urandom));
    issue(FN_ADD_EDGE,   8'h5A, 8'hA5);
    issue(FN_TRAVERSE,   8'h5A, 8'($urandom));
    issue(FN_TRAVERSE,   8'h77, 8'($urandom));
    issue(FN_CLEAR,      8'hFF, 8'hFF);
    issue(FN_TRAVERSE,   8'hFF, 8'($urandom));
    issue(FN_ADD_VERTEX, 8'h80, 8'($urandom));
    issue(FN_ADD_EDGE,   8'h80, 8'h80);
    issue(FN_TRAVERSE,   8'h80, 8'($urandom));
    drain_results();

    // Random episodes; table and list overflow come first
    play_episode(0);
    play_episode(1);
    while (words_sent < ITEM_TARGET) play_episode($urandom_range(0, 7));

    drain_results();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
